/* hw/rtl/csutf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cell selection to UTF-8 text block.
// No dependencies; every other file of the block refers to this package.
package csutf_pkg;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROW_SPAN = 1000000;

  localparam int ROW_W      = 32;
  localparam int COL_W      = 10;
  localparam int RW_W       = 11;
  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int BCNT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Entries in the queue between classifier and encoder
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Cycles that derived selection values need after a register write
  localparam int SETTLE_W      = 2;
  localparam int SETTLE_CYCLES = 2;

  localparam logic [RW_W-1:0]  ROW_WIDTH_RESET = RW_W'(80);
  localparam logic [COL_W-1:0] BLANK_MAX       = COL_W'((1 << COL_W) - 1);
  localparam logic [CP_W-1:0]  CP_SPACE        = CP_W'(32);
  localparam logic [CP_W-1:0]  CP_MAX          = CP_W'(32'h10FFFF);
  localparam logic [CP_W-1:0]  CP_REPLACEMENT  = CP_W'(32'hFFFD);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH  = 3'd0,
    CFG_ANCHOR_ROW = 3'd1,
    CFG_ANCHOR_COL = 3'd2,
    CFG_FOCUS_ROW  = 3'd3,
    CFG_FOCUS_COL  = 3'd4
  } cfg_idx_t;

  // Classified work handed from the front end to the encoder
  typedef struct packed {
    logic [COL_W-1:0] space_run;
    logic [CP_W-1:0]  code_point;
    logic             has_char;
    logic             line_break;
    logic             sel_done;
    logic             span_error;
  } cmd_t;

endpackage

/* hw/rtl/csutf_in_if.sv */
`timescale 1ns / 1ps
// Input cell channel: valid/ready handshake with one terminal cell as payload.
// Depends on csutf_pkg for field widths.
interface csutf_in_if;
  logic                           valid;
  logic                           ready;
  logic [csutf_pkg::ROW_W-1:0]    line_index;
  logic [csutf_pkg::COL_W-1:0]    column;
  logic [csutf_pkg::CP_W-1:0]     code_point;
  logic                           wide_tail;
  logic                           row_present;

  modport source (output valid, line_index, column, code_point, wide_tail, row_present,
                  input ready);
  modport sink   (input valid, line_index, column, code_point, wide_tail, row_present,
                  output ready);
endinterface

/* hw/rtl/csutf_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with space run, UTF-8 bytes and flags.
// Depends on csutf_pkg for field widths.
interface csutf_out_if;
  logic                            valid;
  logic                            ready;
  logic [csutf_pkg::COL_W-1:0]     space_run;
  logic [csutf_pkg::BCNT_W-1:0]    byte_count;
  logic [csutf_pkg::BYTE_W-1:0]    byte_first;
  logic [csutf_pkg::BYTE_W-1:0]    byte_second;
  logic [csutf_pkg::BYTE_W-1:0]    byte_third;
  logic [csutf_pkg::BYTE_W-1:0]    byte_fourth;
  logic                            line_break;
  logic                            selection_done;
  logic                            span_error;

  modport source (output valid, space_run, byte_count, byte_first, byte_second, byte_third,
                         byte_fourth, line_break, selection_done, span_error,
                  input ready);
  modport sink   (input valid, space_run, byte_count, byte_first, byte_second, byte_third,
                        byte_fourth, line_break, selection_done, span_error,
                  output ready);
endinterface

/* hw/rtl/csutf_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on csutf_pkg for field widths.
interface csutf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [csutf_pkg::CFG_IDX_W-1:0]    index;
  logic [csutf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/csutf_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, ordered selection bounds and per-cell
// classification with the blank counter. Depends on csutf_pkg and the channel interfaces.
module csutf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  csutf_in_if.sink              in_ch,
  csutf_cfg_if.sink             cfg_ch,
  input  logic                  q_full,
  output logic                  push,
  output csutf_pkg::cmd_t       push_cmd
);

  logic [csutf_pkg::RW_W-1:0]     row_width_r;
  logic [csutf_pkg::ROW_W-1:0]    anchor_row_r, focus_row_r;
  logic [csutf_pkg::COL_W-1:0]    anchor_col_r, focus_col_r;

  // Derived bounds, registered and refreshed after a write
  logic [csutf_pkg::ROW_W-1:0]    r0_r, r1_r;
  logic [csutf_pkg::COL_W-1:0]    c0_r, c1_r;
  logic [csutf_pkg::COL_W-1:0]    rw_m1_r;
  logic [csutf_pkg::COL_W-1:0]    cend_last_r;
  logic                           span_err_r;
  logic [csutf_pkg::SETTLE_W-1:0] settle_r;

  logic [csutf_pkg::COL_W-1:0]    pend_r, pend_nxt;

  logic                           cfg_fire, in_fire;
  logic                           anchor_first;
  logic [csutf_pkg::COL_W-1:0]    rw_m1_nxt;
  logic                           in_sel, last, first;
  logic [csutf_pkg::COL_W-1:0]    cend, cstart;
  logic                           past_end, is_end, live, blank, printable, emit;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign in_ch.ready  = (settle_r == '0) & ~q_full;
  assign in_fire      = in_ch.valid & in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= csutf_pkg::ROW_WIDTH_RESET;
      anchor_row_r <= '0;
      anchor_col_r <= '0;
      focus_row_r  <= '0;
      focus_col_r  <= '0;
    end else if (cfg_fire) begin
      unique case (csutf_pkg::cfg_idx_t'(cfg_ch.index))
        csutf_pkg::CFG_ROW_WIDTH:  row_width_r  <= cfg_ch.data[csutf_pkg::RW_W-1:0];
        csutf_pkg::CFG_ANCHOR_ROW: anchor_row_r <= cfg_ch.data[csutf_pkg::ROW_W-1:0];
        csutf_pkg::CFG_ANCHOR_COL: anchor_col_r <= cfg_ch.data[csutf_pkg::COL_W-1:0];
        csutf_pkg::CFG_FOCUS_ROW:  focus_row_r  <= cfg_ch.data[csutf_pkg::ROW_W-1:0];
        csutf_pkg::CFG_FOCUS_COL:  focus_col_r  <= cfg_ch.data[csutf_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input off while derived bounds settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= csutf_pkg::SETTLE_W'(csutf_pkg::SETTLE_CYCLES);
    end else if (cfg_fire) begin
      settle_r <= csutf_pkg::SETTLE_W'(csutf_pkg::SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign anchor_first = (anchor_row_r < focus_row_r) ||
                        ((anchor_row_r == focus_row_r) && (anchor_col_r <= focus_col_r));

  always_comb begin
    if (row_width_r == '0) begin
      rw_m1_nxt = '0;
    end else if (row_width_r > csutf_pkg::RW_W'(csutf_pkg::MAX_COLS)) begin
      rw_m1_nxt = csutf_pkg::COL_W'(csutf_pkg::MAX_COLS - 1);
    end else begin
      rw_m1_nxt = csutf_pkg::COL_W'(row_width_r - 1'b1);
    end
  end

  // Stage one orders the endpoints, stage two the span check and last-row end
  always_ff @(posedge clk) begin
    r0_r        <= anchor_first ? anchor_row_r : focus_row_r;
    c0_r        <= anchor_first ? anchor_col_r : focus_col_r;
    r1_r        <= anchor_first ? focus_row_r  : anchor_row_r;
    c1_r        <= anchor_first ? focus_col_r  : anchor_col_r;
    rw_m1_r     <= rw_m1_nxt;
    span_err_r  <= (r1_r - r0_r) >= csutf_pkg::ROW_W'(csutf_pkg::MAX_ROW_SPAN);
    cend_last_r <= (c1_r < rw_m1_r) ? c1_r : rw_m1_r;
  end

  // Classify the offered cell
  always_comb begin
    in_sel    = (in_ch.line_index >= r0_r) && (in_ch.line_index <= r1_r);
    last      = (in_ch.line_index == r1_r);
    first     = (in_ch.line_index == r0_r);
    cend      = last  ? cend_last_r : rw_m1_r;
    cstart    = first ? c0_r : '0;
    past_end  = in_ch.column > cend;
    is_end    = in_ch.column == cend;
    live      = in_sel && in_ch.row_present && !past_end &&
                (in_ch.column >= cstart) && !in_ch.wide_tail;
    blank     = live && ((in_ch.code_point == '0) || (in_ch.code_point == csutf_pkg::CP_SPACE));
    printable = live && !blank;
    emit      = span_err_r ||
                (in_sel && (!in_ch.row_present || (!past_end && (printable || is_end))));

    pend_nxt = pend_r;
    if (!span_err_r && in_sel) begin
      if (!in_ch.row_present) begin
        pend_nxt = '0;
      end else if (!past_end) begin
        if (printable || is_end) begin
          pend_nxt = '0;
        end else if (blank && (pend_r != csutf_pkg::BLANK_MAX)) begin
          pend_nxt = pend_r + 1'b1;
        end
      end
    end

    push_cmd = '0;
    if (span_err_r) begin
      push_cmd.span_error = 1'b1;
    end else if (!in_ch.row_present) begin
      push_cmd.line_break = !last;
      push_cmd.sel_done   = last;
    end else begin
      push_cmd.space_run  = printable ? pend_r : '0;
      push_cmd.code_point = in_ch.code_point;
      push_cmd.has_char   = printable;
      push_cmd.line_break = is_end && !last;
      push_cmd.sel_done   = is_end && last;
    end
  end

  assign push = in_fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_fire) begin
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_settle_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_fire)
    else $error("cell accepted while selection bounds settle");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_fire && !q_full)
    else $error("queue written without an accepted cell");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_cmd.span_error) |->
      (push_cmd.space_run == '0) && !push_cmd.has_char &&
      !push_cmd.line_break && !push_cmd.sel_done)
    else $error("span error item carries other fields");

  a_error_keeps_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && span_err_r) |=> $stable(pend_r))
    else $error("blank counter moved under span error");
`endif

endmodule

/* hw/rtl/csutf_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified work between the front end and the encoder.
// Depends on csutf_pkg for the entry type and depth.
module csutf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csutf_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output csutf_pkg::cmd_t   head,
  output logic              full,
  output logic              empty
);

  csutf_pkg::cmd_t                  slot_r [csutf_pkg::QDEPTH];
  logic [csutf_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [csutf_pkg::QCNT_W-1:0]     count_r;

  assign full  = count_r == csutf_pkg::QCNT_W'(csutf_pkg::QDEPTH);
  assign empty = count_r == '0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/csutf_back.sv */
`timescale 1ns / 1ps
// Back end: UTF-8 encode of the queue head into the registered result stage.
// Depends on csutf_pkg and csutf_out_if.
module csutf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  csutf_pkg::cmd_t   head,
  input  logic              empty,
  output logic              pop,
  csutf_out_if.source       out_ch
);

  logic                            valid_r;
  logic [csutf_pkg::COL_W-1:0]     space_run_r;
  logic [csutf_pkg::BCNT_W-1:0]    byte_count_r;
  logic [csutf_pkg::BYTE_W-1:0]    b0_r, b1_r, b2_r, b3_r;
  logic                            line_break_r, sel_done_r, span_error_r;

  logic [csutf_pkg::CP_W-1:0]      cpv;
  logic [csutf_pkg::BCNT_W-1:0]    cnt_nxt;
  logic [csutf_pkg::BYTE_W-1:0]    b0_nxt, b1_nxt, b2_nxt, b3_nxt;

  always_comb begin
    cpv     = (head.code_point > csutf_pkg::CP_MAX) ? csutf_pkg::CP_REPLACEMENT
                                                    : head.code_point;
    cnt_nxt = '0;
    b0_nxt  = '0;
    b1_nxt  = '0;
    b2_nxt  = '0;
    b3_nxt  = '0;
    if (head.has_char) begin
      if (cpv < csutf_pkg::CP_W'(32'h80)) begin
        cnt_nxt = csutf_pkg::BCNT_W'(1);
        b0_nxt  = {1'b0, cpv[6:0]};
      end else if (cpv < csutf_pkg::CP_W'(32'h800)) begin
        cnt_nxt = csutf_pkg::BCNT_W'(2);
        b0_nxt  = {3'b110, cpv[10:6]};
        b1_nxt  = {2'b10, cpv[5:0]};
      end else if (cpv < csutf_pkg::CP_W'(32'h10000)) begin
        cnt_nxt = csutf_pkg::BCNT_W'(3);
        b0_nxt  = {4'b1110, cpv[15:12]};
        b1_nxt  = {2'b10, cpv[11:6]};
        b2_nxt  = {2'b10, cpv[5:0]};
      end else begin
        cnt_nxt = csutf_pkg::BCNT_W'(4);
        b0_nxt  = {5'b11110, cpv[20:18]};
        b1_nxt  = {2'b10, cpv[17:12]};
        b2_nxt  = {2'b10, cpv[11:6]};
        b3_nxt  = {2'b10, cpv[5:0]};
      end
    end
  end

  // Refill the result stage whenever it is empty or being taken
  assign pop = !empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      space_run_r  <= head.space_run;
      byte_count_r <= cnt_nxt;
      b0_r         <= b0_nxt;
      b1_r         <= b1_nxt;
      b2_r         <= b2_nxt;
      b3_r         <= b3_nxt;
      line_break_r <= head.line_break;
      sel_done_r   <= head.sel_done;
      span_error_r <= head.span_error;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.space_run      = space_run_r;
  assign out_ch.byte_count     = byte_count_r;
  assign out_ch.byte_first     = b0_r;
  assign out_ch.byte_second    = b1_r;
  assign out_ch.byte_third     = b2_r;
  assign out_ch.byte_fourth    = b3_r;
  assign out_ch.line_break     = line_break_r;
  assign out_ch.selection_done = sel_done_r;
  assign out_ch.span_error     = span_error_r;

endmodule

/* hw/rtl/cell_selection_to_utf8_text.sv */
`timescale 1ns / 1ps
// Cell selection to UTF-8 text: top level joining front end, queue and encoder.
// Depends on csutf_pkg, the channel interfaces, csutf_front, csutf_queue, csutf_back.
//
// Usage:
//   in_ch  takes terminal cells in row order, one item per handshake (valid & ready).
//   out_ch gives at most one item per cell: a run of spaces, up to four UTF-8
//          bytes and the newline / done / span error flags.
//   cfg_ch writes row width and the two selection endpoints; it is always ready.
// Path: a cell is classified into the queue, encoded into the output register, then
//   shown on out_ch.
// Throughput: one cell per cycle while the queue has room and no write settles, set by
//   the combinational classifier and the blank counter it updates for every cell.
// After reset, and after every configuration write, in_ch holds ready low while the
//   ordered endpoints and the span check are recomputed.
// When the receiver stalls, the output register holds its item and the four-entry
//   queue absorbs further results; the stall reaches in_ch only once the queue is full.
//   Cells that give no result pass without touching the queue.
module cell_selection_to_utf8_text (
  input  logic          clk,
  input  logic          rst_n,
  csutf_in_if.sink      in_ch,
  csutf_out_if.source   out_ch,
  csutf_cfg_if.sink     cfg_ch
);

  csutf_pkg::cmd_t push_cmd, head;
  logic            push, pop, q_full, q_empty;

  // Classify cells and keep the blank run
  csutf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple classification from output stalls
  csutf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Encode and register the result item
  csutf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* tb/sv/tb_cell_selection_to_utf8_text.sv */
`timescale 1ns / 1ps
// Self-checking bench for cell_selection_to_utf8_text: directed and random cells, own predictor.
// Depends on csutf_pkg, csutf_in_if, csutf_out_if, csutf_cfg_if and the block under test.
module tb_cell_selection_to_utf8_text;

  localparam int IDLE_PERCENT    = 11;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 6;     // quiet margin after the last expected result
  localparam int STALL_LIMIT     = 3000;  // cycles without any handshake before giving up
  localparam int TOTAL_CELLS     = 1350;  // at least this many cells offered over the whole run

  typedef struct packed {
    logic [csutf_pkg::ROW_W-1:0] line_index;
    logic [csutf_pkg::COL_W-1:0] column;
    logic [csutf_pkg::CP_W-1:0]  code_point;
    logic                        wide_tail;
    logic                        row_present;
  } cell_in_t;

  typedef struct packed {
    logic [csutf_pkg::COL_W-1:0]  space_run;
    logic [csutf_pkg::BCNT_W-1:0] byte_count;
    logic [csutf_pkg::BYTE_W-1:0] byte_first;
    logic [csutf_pkg::BYTE_W-1:0] byte_second;
    logic [csutf_pkg::BYTE_W-1:0] byte_third;
    logic [csutf_pkg::BYTE_W-1:0] byte_fourth;
    logic                         line_break;
    logic                         selection_done;
    logic                         span_error;
  } text_item_t;

  logic clk;
  logic rst_n;

  csutf_in_if  in_ch ();
  csutf_out_if out_ch ();
  csutf_cfg_if cfg_ch ();

  cell_selection_to_utf8_text dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the registers and of the blank counter, reset values as in the block
  logic [csutf_pkg::RW_W-1:0]  sel_width      = csutf_pkg::ROW_WIDTH_RESET;
  logic [csutf_pkg::ROW_W-1:0] sel_anchor_row = '0;
  logic [csutf_pkg::COL_W-1:0] sel_anchor_col = '0;
  logic [csutf_pkg::ROW_W-1:0] sel_focus_row  = '0;
  logic [csutf_pkg::COL_W-1:0] sel_focus_col  = '0;
  logic [csutf_pkg::COL_W-1:0] blank_count    = '0;

  text_item_t text_expected[$];
  int         failures      = 0;
  int         cells_sent    = 0;
  bit         no_idle       = 1'b0;
  bit         hold_off_req  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the text item a cell causes, if any, and advance the blank counter.
  function automatic bit predict_text(input cell_in_t c, output text_item_t t);
    logic [csutf_pkg::ROW_W-1:0] r0, r1;
    logic [csutf_pkg::COL_W-1:0] c0, c1, cstart, cend;
    logic [csutf_pkg::ROW_W:0]   span;
    logic [csutf_pkg::RW_W-1:0]  width;
    logic [csutf_pkg::CP_W-1:0]  cp;
    bit                          last, row_end, printable;
    t = '0;
    printable = 1'b0;
    // the smaller (row, column) endpoint opens the selection
    if (sel_anchor_row < sel_focus_row ||
        (sel_anchor_row == sel_focus_row && sel_anchor_col <= sel_focus_col)) begin
      r0 = sel_anchor_row; c0 = sel_anchor_col; r1 = sel_focus_row; c1 = sel_focus_col;
    end else begin
      r0 = sel_focus_row; c0 = sel_focus_col; r1 = sel_anchor_row; c1 = sel_anchor_col;
    end
    span = {1'b0, r1} - {1'b0, r0} + 1'b1;
    if (span > csutf_pkg::MAX_ROW_SPAN) begin
      t.span_error = 1'b1;
      return 1'b1;
    end
    if (c.line_index < r0 || c.line_index > r1) return 1'b0;
    last = (c.line_index == r1);
    if (!c.row_present) begin
      blank_count      = '0;
      t.line_break     = !last;
      t.selection_done = last;
      return 1'b1;
    end
    width = sel_width;
    if (width == '0) width = csutf_pkg::RW_W'(1);
    if (width > csutf_pkg::MAX_COLS) width = csutf_pkg::RW_W'(csutf_pkg::MAX_COLS);
    cend = csutf_pkg::COL_W'(width - 1'b1);
    if (last && c1 < cend) cend = c1;
    cstart = (c.line_index == r0) ? c0 : '0;
    if (c.column > cend) return 1'b0;
    row_end = (c.column == cend);
    if (c.column >= cstart && !c.wide_tail) begin
      if (c.code_point == '0 || c.code_point == csutf_pkg::CP_SPACE) begin
        if (blank_count != csutf_pkg::BLANK_MAX) blank_count++;
      end else begin
        printable = 1'b1;
      end
    end
    if (printable) begin
      t.space_run = blank_count;
      cp = (c.code_point > csutf_pkg::CP_MAX) ? csutf_pkg::CP_REPLACEMENT : c.code_point;
      if (cp < csutf_pkg::CP_W'('h80)) begin
        t.byte_count = csutf_pkg::BCNT_W'(1);
        t.byte_first = cp[7:0];
      end else if (cp < csutf_pkg::CP_W'('h800)) begin
        t.byte_count  = csutf_pkg::BCNT_W'(2);
        t.byte_first  = {3'b110, cp[10:6]};
        t.byte_second = {2'b10, cp[5:0]};
      end else if (cp < csutf_pkg::CP_W'('h10000)) begin
        t.byte_count  = csutf_pkg::BCNT_W'(3);
        t.byte_first  = {4'b1110, cp[15:12]};
        t.byte_second = {2'b10, cp[11:6]};
        t.byte_third  = {2'b10, cp[5:0]};
      end else begin
        t.byte_count  = csutf_pkg::BCNT_W'(4);
        t.byte_first  = {5'b11110, cp[20:18]};
        t.byte_second = {2'b10, cp[17:12]};
        t.byte_third  = {2'b10, cp[11:6]};
        t.byte_fourth = {2'b10, cp[5:0]};
      end
      blank_count = '0;
    end
    if (row_end) begin
      blank_count      = '0;
      t.line_break     = !last;
      t.selection_done = last;
    end
    return printable || row_end;
  endfunction

  function automatic cell_in_t term_cell(input logic [csutf_pkg::ROW_W-1:0] li, input int col,
                                         input logic [csutf_pkg::CP_W-1:0] cp,
                                         input bit wide, input bit present);
    cell_in_t c;
    c.line_index  = li;
    c.column      = csutf_pkg::COL_W'(col);
    c.code_point  = cp;
    c.wide_tail   = wide;
    c.row_present = present;
    return c;
  endfunction

  // Mostly blanks and ASCII, with every UTF-8 length and some out-of-range values
  function automatic logic [csutf_pkg::CP_W-1:0] random_code_point();
    int pick = $urandom_range(99);
    if (pick < 35) return $urandom_range(1) ? csutf_pkg::CP_SPACE : '0;
    if (pick < 65) return csutf_pkg::CP_W'($urandom_range(33, 126));
    if (pick < 75) return csutf_pkg::CP_W'($urandom_range('h80, 'h7FF));
    if (pick < 85) return csutf_pkg::CP_W'($urandom_range('h800, 'hFFFF));
    if (pick < 95) return csutf_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
    return csutf_pkg::CP_W'($urandom_range(0, (1 << csutf_pkg::CP_W) - 1));
  endfunction

  function automatic cell_in_t stray_cell();
    return term_cell($urandom, $urandom_range(0, 1023),
                     csutf_pkg::CP_W'($urandom_range(0, (1 << csutf_pkg::CP_W) - 1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // Offer one cell, idling at random first; valid stays high after the handshake so
  // that the next call can follow on without a gap.
  task automatic send_cell(input cell_in_t c);
    text_item_t t;
    bit         has_text;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.line_index  <= c.line_index;
    in_ch.column      <= c.column;
    in_ch.code_point  <= c.code_point;
    in_ch.wide_tail   <= c.wide_tail;
    in_ch.row_present <= c.row_present;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has_text = predict_text(c, t);
    if (has_text) text_expected.push_back(t);
    cells_sent++;
  endtask

  // Drop valid, wait for every expected item, then let the pipeline go quiet.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (text_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input csutf_pkg::cfg_idx_t idx,
                                input logic [csutf_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      csutf_pkg::CFG_ROW_WIDTH:  sel_width      = data[csutf_pkg::RW_W-1:0];
      csutf_pkg::CFG_ANCHOR_ROW: sel_anchor_row = data[csutf_pkg::ROW_W-1:0];
      csutf_pkg::CFG_ANCHOR_COL: sel_anchor_col = data[csutf_pkg::COL_W-1:0];
      csutf_pkg::CFG_FOCUS_ROW:  sel_focus_row  = data[csutf_pkg::ROW_W-1:0];
      csutf_pkg::CFG_FOCUS_COL:  sel_focus_col  = data[csutf_pkg::COL_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every register once the block has gone idle
  task automatic write_selection(input logic [csutf_pkg::CFG_DATA_W-1:0] width,
                                 input logic [csutf_pkg::CFG_DATA_W-1:0] a_row, a_col,
                                 input logic [csutf_pkg::CFG_DATA_W-1:0] f_row, f_col);
    settle_block();
    write_register(csutf_pkg::CFG_ROW_WIDTH, width);
    write_register(csutf_pkg::CFG_ANCHOR_ROW, a_row);
    write_register(csutf_pkg::CFG_ANCHOR_COL, a_col);
    write_register(csutf_pkg::CFG_FOCUS_ROW, f_row);
    write_register(csutf_pkg::CFG_FOCUS_COL, f_col);
    cfg_ch.valid <= 1'b0;
  endtask

  // Reset values: 80 columns and both endpoints at (0, 0), so one cell is selected.
  task automatic test_reset_defaults();
    send_cell(term_cell(0, 0, csutf_pkg::CP_W'("A"), 1'b0, 1'b1));
    send_cell(term_cell(0, 1, csutf_pkg::CP_W'("B"), 1'b0, 1'b1));   // past the selection end
    send_cell(term_cell(1, 0, csutf_pkg::CP_W'("C"), 1'b0, 1'b1));   // outside the lines
  endtask

  // One selected line, endpoints given in reverse, width written above the clamp.
  // Walks every UTF-8 length boundary, a surrogate, values above U+10FFFF and a
  // skipped wide tail; the trailing blank on the end cell must be trimmed.
  task automatic test_utf8_encoding();
    logic [csutf_pkg::CP_W-1:0] points[12] = '{'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD800, 'hFFFF,
                                               'h10000, 'h10FFFF, 'h110000, 'h1FFFFF, 'h20};
    write_selection(2047, 7, 11, 7, 0);
    for (int i = 0; i < 12; i++) send_cell(term_cell(7, i, points[i], i == 7, 1'b1));
  endtask

  // Row span at the limit, one past it, far past it with the endpoints reversed, and a
  // selection on the very last line; width 0 clamps to a single column.
  task automatic test_span_limit();
    write_selection(0, 0, 0, csutf_pkg::MAX_ROW_SPAN - 1, 0);
    send_cell(term_cell(0, 0, csutf_pkg::CP_W'("x"), 1'b0, 1'b1));
    send_cell(term_cell(csutf_pkg::MAX_ROW_SPAN - 1, 0, csutf_pkg::CP_SPACE, 1'b0, 1'b1));
    write_selection(0, 0, 0, csutf_pkg::MAX_ROW_SPAN, 0);
    send_cell(term_cell(5, 0, csutf_pkg::CP_W'("y"), 1'b0, 1'b1));
    write_selection(1, 32'hFFFF_FFFF, 1023, 0, 1023);
    send_cell(term_cell(32'hFFFF_FFFF, 1023, csutf_pkg::CP_W'('h1FFFFF), 1'b1, 1'b0));
    write_selection(1, 32'hFFFF_FFFF, 1023, 32'hFFFF_FFFF, 0);
    send_cell(term_cell(32'hFFFF_FFFF, 0, csutf_pkg::CP_W'("q"), 1'b0, 1'b1));
  endtask

  // Cells before the start column, a wide tail closing a row, a lost row, a row whose
  // end never comes (its blanks carry on), and cells past the end of the selection.
  task automatic test_lost_and_partial_rows();
    write_selection(4, 10, 2, 13, 1);
    send_cell(term_cell(9, 3, csutf_pkg::CP_W'("n"), 1'b0, 1'b1));
    send_cell(term_cell(10, 0, csutf_pkg::CP_W'("a"), 1'b0, 1'b1));
    send_cell(term_cell(10, 1, csutf_pkg::CP_SPACE, 1'b0, 1'b1));
    send_cell(term_cell(10, 2, '0, 1'b0, 1'b1));
    send_cell(term_cell(10, 3, csutf_pkg::CP_W'("w"), 1'b1, 1'b1));
    send_cell(term_cell(11, 0, csutf_pkg::CP_W'("z"), 1'b0, 1'b0));
    send_cell(term_cell(12, 0, csutf_pkg::CP_SPACE, 1'b0, 1'b1));
    send_cell(term_cell(12, 1, '0, 1'b0, 1'b1));
    send_cell(term_cell(13, 0, csutf_pkg::CP_W'("b"), 1'b0, 1'b1));
    send_cell(term_cell(13, 1, csutf_pkg::CP_SPACE, 1'b0, 1'b1));
    send_cell(term_cell(13, 2, csutf_pkg::CP_W'("c"), 1'b0, 1'b1));
  endtask

  // Receiver holds off while the sender keeps offering printable cells back to back:
  // the queue fills and the input must stall without losing an item.
  task automatic test_receiver_hold_off();
    write_selection(12, 40, 0, 41, 11);
    no_idle      = 1'b1;
    hold_off_req = 1'b1;
    for (int li = 40; li <= 41; li++)
      for (int col = 0; col < 12; col++)
        send_cell(term_cell(li, col, csutf_pkg::CP_W'($urandom_range(33, 126)), 1'b0, 1'b1));
    no_idle = 1'b0;
  endtask

  // Over a thousand blanks without a row end: the counter must stop at its maximum.
  task automatic test_blank_saturation();
    write_selection(csutf_pkg::MAX_COLS, 20, 0, 21, 0);
    no_idle = 1'b1;
    for (int k = 0; k < 1030; k++)
      send_cell(term_cell(20, k % 1023, $urandom_range(1) ? csutf_pkg::CP_SPACE : '0,
                          1'b0, 1'b1));
    send_cell(term_cell(20, 100, csutf_pkg::CP_W'("Z"), 1'b0, 1'b1));
    send_cell(term_cell(20, 1023, '0, 1'b0, 1'b1));
    send_cell(term_cell(21, 0, csutf_pkg::CP_W'("."), 1'b1, 1'b1));
    no_idle = 1'b0;
  endtask

  // Random selections of up to four lines swept in row order from the line before to the line
  // after, with lost rows, cut-short rows and stray cells; over-limit spans get strays only.
  task automatic test_random_selections();
    int                          pick, eff_width, ncols, cut, col, max_col;
    logic [csutf_pkg::RW_W-1:0]  width;
    logic [csutf_pkg::ROW_W-1:0] base, ra, rb, r_lo, r_hi;
    while (cells_sent < TOTAL_CELLS) begin
      pick = $urandom_range(99);
      if (pick < 70)      width = csutf_pkg::RW_W'($urandom_range(1, 12));
      else if (pick < 78) width = '0;
      else if (pick < 92) width = csutf_pkg::RW_W'($urandom_range(13, 2047));
      else                width = csutf_pkg::RW_W'(2047);
      eff_width = (width == '0) ? 1 :
                  ((width > csutf_pkg::MAX_COLS) ? csutf_pkg::MAX_COLS : int'(width));
      max_col   = (eff_width + 1 > 1023) ? 1023 : eff_width + 1;
      if ($urandom_range(99) < 8) begin
        // span beyond the limit: every cell reports the error
        base = $urandom_range(0, 32'hFF00_0000);
        ra   = base + csutf_pkg::MAX_ROW_SPAN + $urandom_range(0, 32'h000F_0000);
        if ($urandom_range(1)) write_selection(32'(width), base, $urandom, ra, $urandom);
        else                   write_selection(32'(width), ra, $urandom, base, $urandom);
        repeat (4) send_cell(stray_cell());
      end else begin
        base = $urandom_range(1, 32'hFFFF_FFF0);
        ra   = base + $urandom_range(0, 3);
        rb   = base + $urandom_range(0, 3);
        write_selection(32'(width), ra, $urandom_range(0, max_col), rb,
                        $urandom_range(0, max_col));
        r_lo  = ((ra < rb) ? ra : rb) - 1;
        r_hi  = ((ra < rb) ? rb : ra) + 1;
        // wide rows send their first eight and last four columns only
        ncols = (eff_width <= 16) ? eff_width : 12;
        for (logic [csutf_pkg::ROW_W-1:0] li = r_lo; li <= r_hi; li++) begin
          if ($urandom_range(99) < 8) begin
            send_cell(term_cell(li, $urandom_range(0, 1023), random_code_point(),
                                1'($urandom_range(1)), 1'b0));
          end else begin
            cut = ($urandom_range(99) < 6) ? $urandom_range(0, ncols - 1) : ncols;
            for (int idx = 0; idx < cut; idx++) begin
              if ($urandom_range(99) < 4) send_cell(stray_cell());
              col = (eff_width <= 16 || idx < 8) ? idx : eff_width - 12 + idx;
              send_cell(term_cell(li, col, random_code_point(),
                                  $urandom_range(99) < 8, 1'b1));
            end
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Compare every accepted result with the oldest expected item
  always @(posedge clk) begin : text_check
    text_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_expected.size() == 0) begin
        $error("result with no expected item: bytes 0x%0h, flags %b%b%b",
               out_ch.byte_first, out_ch.line_break, out_ch.selection_done,
               out_ch.span_error);
        failures++;
      end else begin
        want = text_expected.pop_front();
        check_field("space_run",      want.space_run,      out_ch.space_run);
        check_field("byte_count",     want.byte_count,     out_ch.byte_count);
        check_field("byte_first",     want.byte_first,     out_ch.byte_first);
        check_field("byte_second",    want.byte_second,    out_ch.byte_second);
        check_field("byte_third",     want.byte_third,     out_ch.byte_third);
        check_field("byte_fourth",    want.byte_fourth,    out_ch.byte_fourth);
        check_field("line_break",     want.line_break,     out_ch.line_break);
        check_field("selection_done", want.selection_done, out_ch.selection_done);
        check_field("span_error",     want.span_error,     out_ch.span_error);
      end
    end
  end

  // Receiver: random back-pressure, or a long counted hold-off when asked for
  initial begin : text_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake on any channel
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("cell_selection_to_utf8_text regression: fail");
        $finish;
      end
    end
  end

  initial begin : run_tests
    // hold every input at a known value through reset
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.line_index  <= '0;
    in_ch.column      <= '0;
    in_ch.code_point  <= '0;
    in_ch.wide_tail   <= 1'b0;
    in_ch.row_present <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= csutf_pkg::CFG_ROW_WIDTH;
    cfg_ch.data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_utf8_encoding();
    test_span_limit();
    test_lost_and_partial_rows();
    test_receiver_hold_off();
    test_blank_saturation();
    test_random_selections();

    // drain everything, then wait out DRAIN_CYCLES to catch stray results
    settle_block();
    if (failures == 0)
      $display("cell_selection_to_utf8_text regression: pass");
    else
      $display("cell_selection_to_utf8_text regression: fail");
    $finish;
  end

endmodule

/* cell_selection_to_utf8_text.f */
hw/rtl/csutf_pkg.sv
hw/rtl/csutf_in_if.sv
hw/rtl/csutf_out_if.sv
hw/rtl/csutf_cfg_if.sv
hw/rtl/csutf_front.sv
hw/rtl/csutf_queue.sv
hw/rtl/csutf_back.sv
hw/rtl/cell_selection_to_utf8_text.sv
tb/sv/tb_cell_selection_to_utf8_text.sv
